// ===== design/rrp_pkg.sv =====
package rrp_pkg;

  typedef enum logic [8:0] {
    PH_STAR   = 9'b000000001,
    PH_ALEN   = 9'b000000010,
    PH_ALF    = 9'b000000100,
    PH_DOLLAR = 9'b000001000,
    PH_BLEN   = 9'b000010000,
    PH_BLF    = 9'b000100000,
    PH_DATA   = 9'b001000000,
    PH_TCR    = 9'b010000000,
    PH_TLF    = 9'b100000000
  } phase_e;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ARGEND = 2'd1;
  localparam logic [1:0] KIND_ERR    = 2'd2;

  localparam logic [3:0] ERR_STAR      = 4'd0;
  localparam logic [3:0] ERR_ARR_CRLF  = 4'd1;
  localparam logic [3:0] ERR_ARR_LEN   = 4'd2;
  localparam logic [3:0] ERR_DOLLAR    = 4'd3;
  localparam logic [3:0] ERR_BULK_CRLF = 4'd4;
  localparam logic [3:0] ERR_NULL_BULK = 4'd5;
  localparam logic [3:0] ERR_BULK_LEN  = 4'd6;
  localparam logic [3:0] ERR_TERM      = 4'd7;
  localparam logic [3:0] ERR_EMPTY     = 4'd8;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  // minus-one tracker: nothing yet, saw '-', saw "-1", anything else
  localparam logic [1:0] M1_START = 2'd0;
  localparam logic [1:0] M1_MINUS = 2'd1;
  localparam logic [1:0] M1_NEG1  = 2'd2;
  localparam logic [1:0] M1_OTHER = 2'd3;

  typedef struct packed {
    logic digit;
    logic ovf;
  } len_stat_t;

endpackage

// ===== design/rrp_len_digit.sv =====
// One decimal digit step of the length field: acc * 10 + d, with range check
// against the array or bulk width.
module rrp_len_digit #(
  parameter int COUNT_BITS = 16,
  parameter int LEN_BITS   = 32
) (
  input  logic [((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS)-1:0] acc_i,
  input  logic [7:0]                                                    byte_i,
  input  logic                                                          bulk_i,
  output logic [((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS)-1:0] acc_o,
  output rrp_pkg::len_stat_t                                            stat_o
);

  localparam int AccW = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam int SumW = AccW + 4;

  logic [SumW-1:0] acc_x;
  logic [SumW-1:0] sum;

  assign acc_x = SumW'(acc_i);
  // acc*10 as shift-add; the low nibble of an ASCII digit is its value
  assign sum   = (acc_x << 3) + (acc_x << 1) + SumW'(byte_i[3:0]);
  assign acc_o = sum[AccW-1:0];

  always_comb begin
    stat_o.digit = (byte_i >= rrp_pkg::CH_ZERO) && (byte_i <= rrp_pkg::CH_NINE);
    if (bulk_i) begin
      stat_o.ovf = (sum >> LEN_BITS) != '0;
    end else begin
      stat_o.ovf = (sum >> COUNT_BITS) != '0;
    end
  end

endmodule

// ===== design/resp_request_parser.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | mode_i, data_byte_i
// out     | output    | out_valid_o / out_ready_i| kind_o, payload_o, arg_index_o,
//         |           |                          | last_of_command_o, error_code_o
//
// One byte per cycle sustained while out is not stalled. A byte passes through
// the input register, then its result (if any) lands in the result register;
// the parser state updates in that single pass. Stalls on out hold the input
// register and drop in_ready_o only when both registers are full. Reset puts
// the parser at the array marker with no error pending; no clearing pass is
// needed.
module resp_request_parser #(
  parameter int COUNT_BITS = 16,
  parameter int LEN_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_o,
  output logic [15:0] arg_index_o,
  output logic        last_of_command_o,
  output logic [3:0]  error_code_o
);

  localparam int AccW = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
  localparam int ArgW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // input register
  logic       in_valid_q;
  logic       mode_q;
  logic [7:0] byte_q;

  // parser state
  rrp_pkg::phase_e        phase_q, phase_d;
  logic [COUNT_BITS-1:0]  elem_q, elem_d;
  logic [COUNT_BITS-1:0]  arg_q, arg_d;
  logic [LEN_BITS-1:0]    bytes_q, bytes_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic                   seen_q, seen_d;
  logic                   bad_q, bad_d;
  logic [1:0]             m1_q, m1_d;
  logic                   tbad_q, tbad_d;
  logic                   sticky_q, sticky_d;

  // result register
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  payload_q;
  logic [15:0] arg_index_q;
  logic        last_q;
  logic [3:0]  err_q;

  logic        res_valid;
  logic [1:0]  res_kind;
  logic [7:0]  res_pay;
  logic        res_last;
  logic [3:0]  res_err;
  logic [15:0] res_arg;
  logic [ArgW-1:0] arg_ext;

  logic                advance;
  logic [AccW-1:0]     acc_step;
  rrp_pkg::len_stat_t  len_stat;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  rrp_len_digit #(
    .COUNT_BITS (COUNT_BITS),
    .LEN_BITS   (LEN_BITS)
  ) u_len_digit (
    .acc_i  (acc_q),
    .byte_i (byte_q),
    .bulk_i (phase_q == rrp_pkg::PH_BLEN),
    .acc_o  (acc_step),
    .stat_o (len_stat)
  );

  always_comb begin
    phase_d   = phase_q;
    elem_d    = elem_q;
    arg_d     = arg_q;
    bytes_d   = bytes_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    bad_d     = bad_q;
    m1_d      = m1_q;
    tbad_d    = tbad_q;
    sticky_d  = sticky_q;
    res_valid = 1'b0;
    res_kind  = rrp_pkg::KIND_DATA;
    res_pay   = '0;
    res_last  = 1'b0;
    res_err   = rrp_pkg::ERR_STAR;

    if (mode_q) begin
      phase_d  = rrp_pkg::PH_STAR;
      elem_d   = '0;
      arg_d    = '0;
      bytes_d  = '0;
      acc_d    = '0;
      seen_d   = 1'b0;
      bad_d    = 1'b0;
      m1_d     = rrp_pkg::M1_START;
      tbad_d   = 1'b0;
      sticky_d = 1'b0;
    end else if (!sticky_q) begin
      case (phase_q)
        rrp_pkg::PH_STAR, rrp_pkg::PH_DOLLAR: begin
          if ((phase_q == rrp_pkg::PH_STAR && byte_q != rrp_pkg::CH_STAR) ||
              (phase_q == rrp_pkg::PH_DOLLAR && byte_q != rrp_pkg::CH_DOLLAR)) begin
            res_valid = 1'b1;
            res_kind  = rrp_pkg::KIND_ERR;
            res_err   = (phase_q == rrp_pkg::PH_STAR) ? rrp_pkg::ERR_STAR
                                                       : rrp_pkg::ERR_DOLLAR;
            sticky_d  = 1'b1;
          end else begin
            acc_d   = '0;
            seen_d  = 1'b0;
            bad_d   = 1'b0;
            m1_d    = rrp_pkg::M1_START;
            phase_d = (phase_q == rrp_pkg::PH_STAR) ? rrp_pkg::PH_ALEN
                                                     : rrp_pkg::PH_BLEN;
          end
        end
        rrp_pkg::PH_ALEN, rrp_pkg::PH_BLEN: begin
          if (byte_q == rrp_pkg::CH_CR) begin
            phase_d = (phase_q == rrp_pkg::PH_ALEN) ? rrp_pkg::PH_ALF
                                                     : rrp_pkg::PH_BLF;
          end else begin
            if (!len_stat.digit) begin
              bad_d = 1'b1;
            end else if (!bad_q) begin
              if (len_stat.ovf) begin
                bad_d = 1'b1;
              end else begin
                acc_d = acc_step;
              end
            end
            seen_d = 1'b1;
            case (m1_q)
              rrp_pkg::M1_START: begin
                m1_d = (byte_q == rrp_pkg::CH_MINUS) ? rrp_pkg::M1_MINUS
                                                      : rrp_pkg::M1_OTHER;
              end
              rrp_pkg::M1_MINUS: begin
                m1_d = (byte_q == rrp_pkg::CH_ONE) ? rrp_pkg::M1_NEG1
                                                    : rrp_pkg::M1_OTHER;
              end
              default: m1_d = rrp_pkg::M1_OTHER;
            endcase
          end
        end
        rrp_pkg::PH_ALF: begin
          if (byte_q != rrp_pkg::CH_LF) begin
            res_valid = 1'b1;
            res_kind  = rrp_pkg::KIND_ERR;
            res_err   = rrp_pkg::ERR_ARR_CRLF;
            sticky_d  = 1'b1;
          end else if (!seen_q || bad_q) begin
            res_valid = 1'b1;
            res_kind  = rrp_pkg::KIND_ERR;
            res_err   = rrp_pkg::ERR_ARR_LEN;
            sticky_d  = 1'b1;
          end else if (acc_q == '0) begin
            res_valid = 1'b1;
            res_kind  = rrp_pkg::KIND_ERR;
            res_err   = rrp_pkg::ERR_EMPTY;
            sticky_d  = 1'b1;
          end else begin
            elem_d  = acc_q[COUNT_BITS-1:0];
            arg_d   = '0;
            phase_d = rrp_pkg::PH_DOLLAR;
          end
        end
        rrp_pkg::PH_BLF: begin
          if (byte_q != rrp_pkg::CH_LF) begin
            res_valid = 1'b1;
            res_kind  = rrp_pkg::KIND_ERR;
            res_err   = rrp_pkg::ERR_BULK_CRLF;
            sticky_d  = 1'b1;
          end else if (!seen_q || bad_q) begin
            res_valid = 1'b1;
            res_kind  = rrp_pkg::KIND_ERR;
            res_err   = (m1_q == rrp_pkg::M1_NEG1) ? rrp_pkg::ERR_NULL_BULK
                                                    : rrp_pkg::ERR_BULK_LEN;
            sticky_d  = 1'b1;
          end else begin
            bytes_d = acc_q[LEN_BITS-1:0];
            phase_d = (acc_q == '0) ? rrp_pkg::PH_TCR : rrp_pkg::PH_DATA;
          end
        end
        rrp_pkg::PH_DATA: begin
          res_valid = 1'b1;
          res_kind  = rrp_pkg::KIND_DATA;
          res_pay   = byte_q;
          // command name is folded to upper case
          if (arg_q == '0 && byte_q inside {[rrp_pkg::CH_LA:rrp_pkg::CH_LZ]}) begin
            res_pay = byte_q - rrp_pkg::CASE_GAP;
          end
          bytes_d = bytes_q - LEN_BITS'(1);
          if (bytes_q == LEN_BITS'(1)) begin
            phase_d = rrp_pkg::PH_TCR;
          end
        end
        rrp_pkg::PH_TCR: begin
          tbad_d  = (byte_q != rrp_pkg::CH_CR);
          phase_d = rrp_pkg::PH_TLF;
        end
        rrp_pkg::PH_TLF: begin
          if (tbad_q || byte_q != rrp_pkg::CH_LF) begin
            res_valid = 1'b1;
            res_kind  = rrp_pkg::KIND_ERR;
            res_err   = rrp_pkg::ERR_TERM;
            sticky_d  = 1'b1;
          end else begin
            res_valid = 1'b1;
            res_kind  = rrp_pkg::KIND_ARGEND;
            res_last  = (elem_q == COUNT_BITS'(1));
            elem_d    = elem_q - COUNT_BITS'(1);
            arg_d     = arg_q + COUNT_BITS'(1);
            phase_d   = (elem_q == COUNT_BITS'(1)) ? rrp_pkg::PH_STAR
                                                    : rrp_pkg::PH_DOLLAR;
          end
        end
        default: phase_d = rrp_pkg::PH_STAR;
      endcase
    end
  end

  assign arg_ext = ArgW'(arg_q);
  assign res_arg = (res_kind == rrp_pkg::KIND_ERR) ? 16'd0 : arg_ext[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= rrp_pkg::PH_STAR;
      elem_q      <= '0;
      arg_q       <= '0;
      bytes_q     <= '0;
      acc_q       <= '0;
      seen_q      <= 1'b0;
      bad_q       <= 1'b0;
      m1_q        <= rrp_pkg::M1_START;
      tbad_q      <= 1'b0;
      sticky_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= res_valid;
        phase_q     <= phase_d;
        elem_q      <= elem_d;
        arg_q       <= arg_d;
        bytes_q     <= bytes_d;
        acc_q       <= acc_d;
        seen_q      <= seen_d;
        bad_q       <= bad_d;
        m1_q        <= m1_d;
        tbad_q      <= tbad_d;
        sticky_q    <= sticky_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      mode_q <= mode_i;
      byte_q <= data_byte_i;
    end
    if (advance && res_valid) begin
      kind_q      <= res_kind;
      payload_q   <= res_pay;
      arg_index_q <= res_arg;
      last_q      <= res_last;
      err_q       <= (res_kind == rrp_pkg::KIND_ERR) ? res_err : rrp_pkg::ERR_STAR;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign payload_o         = payload_q;
  assign arg_index_o       = arg_index_q;
  assign last_of_command_o = last_q;
  assign error_code_o      = err_q;

endmodule

// ===== design/rrp_checker.sv =====
module rrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  payload_o,
  input logic [15:0] arg_index_o,
  input logic        last_of_command_o,
  input logic [3:0]  error_code_o
);

  // error results carry only the code
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == rrp_pkg::KIND_ERR |->
      arg_index_o == 16'd0 && payload_o == 8'd0 && !last_of_command_o)
    else $error("error result carries stray fields");

  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == rrp_pkg::KIND_DATA |->
      error_code_o == rrp_pkg::ERR_STAR && !last_of_command_o)
    else $error("payload result carries stray fields");

  a_argend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == rrp_pkg::KIND_ARGEND |->
      payload_o == 8'd0 && error_code_o == rrp_pkg::ERR_STAR)
    else $error("argument end carries stray fields");

  // sticky error: nothing follows an error transfer right away
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && kind_o == rrp_pkg::KIND_ERR |=> !out_valid_o)
    else $error("result right after error transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(kind_o) && $stable(payload_o) && $stable(error_code_o))
    else $error("stalled result changed");

endmodule

bind resp_request_parser rrp_checker u_rrp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .kind_o            (kind_o),
  .payload_o         (payload_o),
  .arg_index_o       (arg_index_o),
  .last_of_command_o (last_of_command_o),
  .error_code_o      (error_code_o)
);
